// ===== sv/wso_pkg.sv =====
// ----------------------------------------------------------------------------
// wso_pkg
// Shared types, constants and state encoding for the weighted slope one engine.
// ----------------------------------------------------------------------------
package wso_pkg;

	localparam int NUM_ITEMS = 256;
	localparam int MAX_ROW = 64;
	localparam int ITEM_W = $clog2(NUM_ITEMS);
	localparam int CELL_W = 2 * ITEM_W;
	localparam int CELLS = NUM_ITEMS * NUM_ITEMS;
	localparam int ROW_W = $clog2(MAX_ROW);
	localparam int FILL_W = ROW_W + 1;
	localparam int RAT_W = 11;
	localparam int DEV_W = 32;
	localparam int CNT_W = 16;
	localparam int PSUM_W = 48;
	localparam int CSUM_W = 24;
	localparam int ADDR_W = 4;

	localparam logic ACT_TRAIN = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [1:0] ST_PRED = 2'd0;
	localparam logic [1:0] ST_MEAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	localparam logic [ADDR_W-1:0] REG_MEAN = 4'h0;
	localparam logic [ADDR_W-1:0] REG_FLOOR = 4'h4;
	localparam logic [ADDR_W-1:0] REG_CEIL = 4'h8;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_TR_RD,
		S_TR_WAIT,
		S_TR_WR,
		S_TR_PUSH,
		S_Q_RD,
		S_Q_WAIT,
		S_Q_MUL,
		S_Q_ACC,
		S_DIV_GO,
		S_DIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic clr_step;     // write zero at clear address, advance
		logic latch_in;     // capture input word
		logic tr_write;     // write both updated cells, advance k
		logic tr_push;      // append entry to row buffer
		logic tr_end;       // clear row state at run end
		logic q_read;       // address the target cell
		logic q_mul;        // register deviation sum plus rating times count
		logic q_acc;        // accumulate
		logic div_start;
		logic q_end;        // clear query sums
		logic out_load;     // load output register
		logic out_train;    // output is training status
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic act;          // latched action
		logic last;
		logic valid_item;   // item in range; for a query also target in range and not the item
		logic row_full;
		logic k_done;       // all buffered entries paired
		logic div_busy;
	} sts_t;

endpackage

// ===== sv/wso_div.sv =====
// ----------------------------------------------------------------------------
// wso_div
// Restoring divider: 48-bit unsigned dividend by 24-bit divisor, one bit/cycle.
// ----------------------------------------------------------------------------
module wso_div import wso_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PSUM_W-1:0] dividend,
	input  logic [CSUM_W-1:0] divisor,
	output logic              busy,
	output logic [PSUM_W-1:0] quotient
);

	logic [PSUM_W-1:0] quo_q;
	logic [CSUM_W:0]   rem_q;
	logic [CSUM_W-1:0] dvs_q;
	logic [5:0]        cnt_q;
	logic              busy_q;
	logic [CSUM_W:0]   trial;
	logic [CSUM_W:0]   diff;

	assign trial = {rem_q[CSUM_W-1:0], quo_q[PSUM_W-1]};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'(PSUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[CSUM_W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[PSUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[PSUM_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

endmodule

// ===== sv/wso_datapath.sv =====
// ----------------------------------------------------------------------------
// wso_datapath
// Pair memories, row buffer, query accumulators, divider and output register.
// ----------------------------------------------------------------------------
module wso_datapath import wso_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic              action,
	input  logic [ITEM_W-1:0] item_index,
	input  logic [RAT_W-1:0]  rating,
	input  logic [ITEM_W-1:0] target_item,
	input  logic              last_of_run,
	input  logic [RAT_W-1:0]  global_mean,
	input  logic [RAT_W-1:0]  rating_floor,
	input  logic [RAT_W-1:0]  rating_ceiling,
	output logic [RAT_W-1:0]  predicted_rating,
	output logic [1:0]        status
);

	localparam logic signed [PSUM_W+1:0] SUM_HI = {3'b000, {(PSUM_W-1){1'b1}}};
	localparam logic signed [PSUM_W+1:0] SUM_LO = {3'b111, {(PSUM_W-1){1'b0}}};

	logic [DEV_W-1:0] dev_mem [CELLS];
	logic [CNT_W-1:0] cnt_mem [CELLS];
	logic [ITEM_W-1:0] row_items [MAX_ROW];
	logic [RAT_W-1:0]  row_ratings [MAX_ROW];

	logic              act_q, last_q;
	logic [ITEM_W-1:0] item_q, tgt_q;
	logic [RAT_W-1:0]  rat_q;
	logic [CELL_W-1:0] clr_q;
	logic              clr_done_q;
	logic [FILL_W-1:0] fill_q, k_q;
	logic              ovf_q;
	logic [ITEM_W-1:0] pitem_q;
	logic [RAT_W-1:0]  prat_q;
	logic [DEV_W-1:0]  devf_q, devr_q;  // forward cell item,row and reverse
	logic [CNT_W-1:0]  cntf_q, cntr_q;
	logic [PSUM_W-1:0] term_q;
	logic signed [PSUM_W-1:0] psum_q;
	logic [CSUM_W-1:0] csum_q;
	logic [RAT_W-1:0]  pr_q;
	logic [1:0]        st_q;

	logic [CELL_W-1:0] cell_f, cell_r, cell_a, cell_b;
	logic              we;
	logic [DEV_W-1:0]  wd_a, wd_b;
	logic [CNT_W-1:0]  wc_a, wc_b;
	logic signed [DEV_W-1:0] diff;
	logic              div_busy;
	logic [PSUM_W-1:0] quo;
	logic signed [PSUM_W+1:0] sum_ext;
	logic [CSUM_W:0]   csum_ext;

	assign cell_f = {item_q, pitem_q};
	assign cell_r = {pitem_q, item_q};

	// Row buffer write, and registered read of entry k.
	always_ff @(posedge clk) begin
		if (cmd.tr_push && !fill_q[ROW_W]) begin
			row_items[fill_q[ROW_W-1:0]] <= item_q;
			row_ratings[fill_q[ROW_W-1:0]] <= rat_q;
		end
		pitem_q <= row_items[k_q[ROW_W-1:0]];
		prat_q <= row_ratings[k_q[ROW_W-1:0]];
	end

	assign diff = DEV_W'($signed({1'b0, rat_q})) - DEV_W'($signed({1'b0, prat_q}));

	// Two ports: port A serves forward/target cell, port B the reverse cell.
	always_comb begin
		we = 1'b0;
		cell_a = cmd.q_read ? {tgt_q, item_q} : cell_f;
		cell_b = cell_r;
		wd_a = devf_q;
		wc_a = cntf_q;
		wd_b = devr_q;
		wc_b = cntr_q;
		if (cmd.clr_step) begin
			we = 1'b1;
			cell_a = clr_q;
			cell_b = clr_q;
			wd_a = '0;
			wc_a = '0;
			wd_b = '0;
			wc_b = '0;
		end else if (cmd.tr_write) begin
			we = 1'b1;
			if (cntf_q != '1) begin
				wd_a = devf_q + diff;
				wc_a = cntf_q + CNT_W'(1);
			end
			if (cntr_q != '1) begin
				wd_b = devr_q - diff;
				wc_b = cntr_q + CNT_W'(1);
			end
		end
	end

	// A diagonal pair puts both directions on one cell. That cell never takes
	// part in a prediction, so only the port A update is stored there.
	always_ff @(posedge clk) begin
		if (we) begin
			dev_mem[cell_a] <= wd_a;
			cnt_mem[cell_a] <= wc_a;
			if (cell_b != cell_a) begin
				dev_mem[cell_b] <= wd_b;
				cnt_mem[cell_b] <= wc_b;
			end
		end
		devf_q <= dev_mem[cell_a];
		cntf_q <= cnt_mem[cell_a];
		devr_q <= dev_mem[cell_b];
		cntr_q <= cnt_mem[cell_b];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			act_q <= action;
			last_q <= last_of_run;
			item_q <= item_index;
			tgt_q <= target_item;
			rat_q <= rating;
		end
		if (cmd.q_mul) begin
			term_q <= PSUM_W'($signed(devf_q)) + PSUM_W'(rat_q) * PSUM_W'(cntf_q);
		end
	end

	assign sum_ext = (PSUM_W+2)'(psum_q) + (PSUM_W+2)'($signed(term_q));
	assign csum_ext = {1'b0, csum_q} + (CSUM_W+1)'(cntf_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			clr_done_q <= 1'b0;
			fill_q <= '0;
			k_q <= '0;
			ovf_q <= 1'b0;
			psum_q <= '0;
			csum_q <= '0;
			pr_q <= '0;
			st_q <= ST_PRED;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + CELL_W'(1);
				if (clr_q == '1) begin
					clr_done_q <= 1'b1;
				end
			end
			if (cmd.latch_in) begin
				k_q <= '0;
			end
			if (cmd.tr_write) begin
				k_q <= k_q + FILL_W'(1);
			end
			if (cmd.tr_push) begin
				if (fill_q[ROW_W]) begin
					ovf_q <= 1'b1;
				end else begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
			if (cmd.tr_end) begin
				fill_q <= '0;
				ovf_q <= 1'b0;
			end
			if (cmd.q_acc && cntf_q != '0) begin
				if (sum_ext > SUM_HI) begin
					psum_q <= {1'b0, {(PSUM_W-1){1'b1}}};
				end else if (sum_ext < SUM_LO) begin
					psum_q <= {1'b1, {(PSUM_W-1){1'b0}}};
				end else begin
					psum_q <= sum_ext[PSUM_W-1:0];
				end
				csum_q <= csum_ext[CSUM_W] ? '1 : csum_ext[CSUM_W-1:0];
			end
			if (cmd.q_end) begin
				psum_q <= '0;
				csum_q <= '0;
			end
			if (cmd.out_load) begin
				if (cmd.out_train) begin
					pr_q <= '0;
					st_q <= ovf_q ? ST_TRUNC : ST_DONE;
				end else if (psum_q <= 0 || csum_q == '0) begin
					pr_q <= global_mean;
					st_q <= ST_MEAN;
				end else if (quo > PSUM_W'(rating_ceiling)) begin
					pr_q <= rating_ceiling;
					st_q <= ST_PRED;
				end else if (quo < PSUM_W'(rating_floor)) begin
					pr_q <= rating_floor;
					st_q <= ST_PRED;
				end else begin
					pr_q <= quo[RAT_W-1:0];
					st_q <= ST_PRED;
				end
			end
		end
	end

	wso_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (psum_q),
		.divisor  (csum_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	assign sts.clr_done = clr_done_q;
	assign sts.act = act_q;
	assign sts.last = last_q;
	assign sts.valid_item = (32'(item_q) < NUM_ITEMS) && (!act_q || (32'(tgt_q) < NUM_ITEMS
		&& item_q != tgt_q));
	assign sts.row_full = fill_q[ROW_W];
	assign sts.k_done = (k_q == fill_q);
	assign sts.div_busy = div_busy;

	assign predicted_rating = pr_q;
	assign status = st_q;

endmodule

// ===== sv/wso_ctrl.sv =====
// ----------------------------------------------------------------------------
// wso_ctrl
// Sequencer for clearing, training pair updates, queries and output handoff.
// ----------------------------------------------------------------------------
module wso_ctrl import wso_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   ov_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (sts.clr_done) state_d = S_IDLE;
			S_IDLE: if (in_valid) state_d = S_TR_RD;
			S_TR_RD: begin
				if (sts.act) begin
					state_d = S_Q_RD;
				end else if (!sts.valid_item || sts.row_full || sts.k_done) begin
					state_d = S_TR_PUSH;
				end else begin
					state_d = S_TR_WAIT;
				end
			end
			S_TR_WAIT: state_d = S_TR_WR;
			S_TR_WR: state_d = S_TR_RD;
			S_TR_PUSH: state_d = sts.last ? S_OUT : S_IDLE;
			S_Q_RD: state_d = S_Q_WAIT;
			S_Q_WAIT: state_d = S_Q_MUL;
			S_Q_MUL: state_d = S_Q_ACC;
			S_Q_ACC: state_d = sts.last ? S_DIV_GO : S_IDLE;
			S_DIV_GO: state_d = S_DIV;
			S_DIV: if (!sts.div_busy) state_d = S_OUT;
			S_OUT: if (!ov_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// S_TR_RD fetches row entry k (registered); S_TR_WAIT reads the pair cells
	// using the fetched entry. The target cell address is held from S_Q_RD
	// through S_Q_MUL so that the count is still valid for accumulation.
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: cmd.clr_step = 1'b1;
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.latch_in = in_valid;
			end
			S_TR_WR: cmd.tr_write = 1'b1;
			S_TR_PUSH: begin
				cmd.tr_push = sts.valid_item;
			end
			S_Q_MUL: cmd.q_mul = 1'b1;
			S_Q_ACC: begin
				cmd.q_acc = sts.valid_item;
			end
			S_DIV_GO: cmd.div_start = 1'b1;
			S_OUT: begin
				cmd.out_load = !ov_q || out_ready;
				cmd.out_train = !sts.act;
				cmd.tr_end = cmd.out_load && !sts.act;
				cmd.q_end = cmd.out_load && sts.act;
			end
			default: cmd = '0;
		endcase
		cmd.q_read = (state_q == S_Q_RD) || (state_q == S_Q_WAIT) || (state_q == S_Q_MUL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;

endmodule

// ===== sv/weighted_slope_one_engine.sv =====
// ----------------------------------------------------------------------------
// weighted_slope_one_engine
// Weighted slope one recommender: trains pair deviations, predicts ratings.
// ----------------------------------------------------------------------------
// After reset the engine sweeps both pair memories to zero, one cell a cycle,
// and accepts no word until that pass ends. A training word pairs its item
// with each entry already buffered in the run, and each such pair is a
// read-modify-write of two cells of the deviation and count memories; a word
// that finds the row full makes no pair update. The last word of a training
// run then loads its result; the last word of a query run goes through the
// divider start, its 48 bit-serial steps, its finish and the load of the
// result. One result word is produced for each last-of-run word and is held
// in an output register; the engine keeps taking input while that register
// waits and stalls only when a further result word is ready to be loaded.
// Ratings and predictions are unsigned with 8 fraction bits.
module weighted_slope_one_engine import wso_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              valid,
	output logic              ready,
	input  logic              action,
	input  logic [ITEM_W-1:0] item_index,
	input  logic [RAT_W-1:0]  rating,
	input  logic [ITEM_W-1:0] target_item,
	input  logic              last_of_run,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [RAT_W-1:0]  predicted_rating,
	output logic [1:0]        status
);

	logic [RAT_W-1:0] mean_q, floor_q, ceil_q;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	// Configuration registers, written in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q <= '0;
			floor_q <= 11'd256;
			ceil_q <= 11'd1280;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				REG_MEAN: mean_q <= pwdata[RAT_W-1:0];
				REG_FLOOR: floor_q <= pwdata[RAT_W-1:0];
				REG_CEIL: ceil_q <= pwdata[RAT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			REG_MEAN: prdata = 32'(mean_q);
			REG_FLOOR: prdata = 32'(floor_q);
			REG_CEIL: prdata = 32'(ceil_q);
			default: prdata = '0;
		endcase
	end

	wso_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid),
		.in_ready  (ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	wso_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.action           (action),
		.item_index       (item_index),
		.rating           (rating),
		.target_item      (target_item),
		.last_of_run      (last_of_run),
		.global_mean      (mean_q),
		.rating_floor     (floor_q),
		.rating_ceiling   (ceil_q),
		.predicted_rating (predicted_rating),
		.status           (status)
	);

endmodule
